// File: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  localparam int unsigned ValueWidth        = 32;
  localparam int unsigned InDataWidth       = 32;
  localparam int unsigned CharWidth         = 6;
  localparam int unsigned OutDataWidth      = 8;
  localparam int unsigned DigitWidth        = 4;
  localparam int unsigned DigitsMax         = 10;
  localparam int unsigned DigitIdxWidth     = 4;
  localparam int unsigned DefaultQueueDepth = 2;

  // reciprocal of ten, exact for every 32-bit unsigned dividend
  localparam logic [ValueWidth-1:0] Recip10    = 32'hCCCC_CCCD;
  localparam int unsigned           RecipShift = 35;
  localparam int unsigned           QuotWidth  = 2 * ValueWidth - RecipShift;

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    StIdle,
    StExtract,
    StEmit
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts signed 32-bit integers into their decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream takes one request per number, tdata holds the signed value.
//   master stream gives one character per transfer: '-' for a negative
//   value, then the digits most significant first, no leading zeros;
//   tlast marks the final character of each number.
//   the front splits sign and magnitude and pushes into a short queue, so
//   new requests are taken while the back still converts or waits.
//   the back pops one entry, extracts one digit per cycle with a
//   reciprocal multiply, then emits one character per cycle, while the
//   receiver accepts, from its output register.
//   reset clears the queue, output valid and the back's state, so a conversion in flight is dropped.
//   when the receiver stalls, the output register holds its character and
//   the queue fills; tready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int unsigned QueueDepth = sitda_pkg::DefaultQueueDepth
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [sitda_pkg::InDataWidth-1:0]  s_axis_tdata,   // [31:0] value
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [sitda_pkg::OutDataWidth-1:0] m_axis_tdata,   // [5:0] text_char, [7:6] zero
  output logic                               m_axis_tlast    // last_char
);
  import sitda_pkg::*;

  item_t     push_item;
  item_t     pop_item;
  q_status_t status;
  logic      push;
  logic      pop;

  sitda_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .status_i      (status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  sitda_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (status)
  );

  sitda_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (status),
    .pop_o         (pop),
    .pop_item_i    (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/sitda_fifo.sv
// ----------------------------------------------------------------------------
// sitda_fifo
// Short request queue between the front and the back of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_fifo #(
  parameter int unsigned Depth = sitda_pkg::DefaultQueueDepth
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  sitda_pkg::item_t  push_item_i,
  input  wire               pop_i,
  output sitda_pkg::item_t  pop_item_o,
  output sitda_pkg::q_status_t status_o
);
  import sitda_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  item_t               mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == CntWidth'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sitda_front.sv
// ----------------------------------------------------------------------------
// sitda_front
// Accepts requests and splits each value into sign and magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_front (
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire  [sitda_pkg::InDataWidth-1:0]      s_axis_tdata,
  input  sitda_pkg::q_status_t                   status_i,
  output logic                                   push_o,
  output sitda_pkg::item_t                       push_item_o
);
  import sitda_pkg::*;

  logic [ValueWidth-1:0] raw;
  logic                  neg;

  assign raw = s_axis_tdata[ValueWidth-1:0];
  assign neg = raw[ValueWidth-1];

  // two's complement negate, most negative value maps to 2^31 unsigned
  assign push_item_o.neg = neg;
  assign push_item_o.mag = neg ? (~raw + 1'b1) : raw;

  assign s_axis_tready = !status_i.full;
  assign push_o        = s_axis_tvalid && !status_i.full;

endmodule

`default_nettype wire

// File: rtl/sitda_back.sv
// ----------------------------------------------------------------------------
// sitda_back
// Extracts decimal digits one per cycle and emits the characters in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_back (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  sitda_pkg::q_status_t                  status_i,
  output logic                                  pop_o,
  input  sitda_pkg::item_t                      pop_item_i,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [sitda_pkg::OutDataWidth-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import sitda_pkg::*;

  back_state_e              state_q, state_d;
  logic [ValueWidth-1:0]    mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [DigitIdxWidth-1:0] cnt_q, cnt_d;
  logic [DigitIdxWidth-1:0] idx_q, idx_d;
  logic [DigitWidth-1:0]    digit_q [DigitsMax];
  logic                     tvalid_q, tvalid_d;
  logic [CharWidth-1:0]     char_q, char_d;
  logic                     last_q, last_d;

  logic [2*ValueWidth-1:0]  prod;
  logic [ValueWidth-1:0]    quot;
  logic [DigitWidth-1:0]    quot_lo;
  logic [DigitWidth-1:0]    digit;
  logic                     load_ok;

  // divide by ten through the reciprocal
  assign prod     = {{ValueWidth{1'b0}}, mag_q} * {{ValueWidth{1'b0}}, Recip10};
  assign quot     = ValueWidth'(prod[2*ValueWidth-1:RecipShift]);
  // remainder is below ten, so the low bits of the difference suffice
  assign quot_lo  = quot[DigitWidth-1:0];
  assign digit    = mag_q[DigitWidth-1:0] - ((quot_lo << 3) + (quot_lo << 1));
  assign load_ok  = !tvalid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!status_i.empty) begin
          state_d = StExtract;
        end
      end
      StExtract: begin
        if (quot == '0) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (load_ok && !neg_q && (idx_q == '0)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mag_d    = mag_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    tvalid_d = tvalid_q;
    char_d   = char_q;
    last_d   = last_q;
    if (m_axis_tready) begin
      tvalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (!status_i.empty) begin
          pop_o = 1'b1;
          mag_d = pop_item_i.mag;
          neg_d = pop_item_i.neg;
          cnt_d = '0;
        end
      end
      StExtract: begin
        mag_d = quot;
        cnt_d = cnt_q + 1'b1;
        idx_d = cnt_q;
      end
      StEmit: begin
        if (load_ok) begin
          tvalid_d = 1'b1;
          if (neg_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = CharZero + CharWidth'(digit_q[idx_q]);
            last_d = (idx_q == '0);
            if (idx_q != '0) begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tvalid_q <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      tvalid_q <= tvalid_d;
      neg_q    <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
    if (state_q == StExtract) begin
      digit_q[cnt_q] <= digit;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = OutDataWidth'(char_q);
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

// File: rtl/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the converter's character stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [sitda_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input wire                                m_axis_tlast
);
  import sitda_pkg::*;

  logic is_minus;
  logic is_digit;

  assign is_minus = (m_axis_tdata == OutDataWidth'(CharMinus));
  assign is_digit = (m_axis_tdata >= OutDataWidth'(CharZero))
                 && (m_axis_tdata <= OutDataWidth'(CharZero) + OutDataWidth'(9));

  // only minus or decimal digits leave the block
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (is_minus || is_digit))
    else $error("character outside minus and digit codes");

  // a number never ends on its sign
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && is_minus) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

  // characters of one number follow with no gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside a number's text");

  // stalled character holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
